// ===== src/melody_note_sequencer_assert.svh =====
// Assertion macros for the melody note sequencer.
// Included by the top level; needs clock and reset in the including scope.
`ifndef MELODY_NOTE_SEQUENCER_ASSERT_SVH
`define MELODY_NOTE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MNS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define MNS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mns_pkg.sv =====
// Shared types and codes for the melody note sequencer.
// No dependencies; imported by every module of the block.
package mns_pkg;

   // Field widths
   localparam int OP_W     = 2;
   localparam int ACT_W    = 2;
   localparam int ADDR_W   = 6;
   localparam int FREQ_W   = 20;
   localparam int DUR_W    = 16;
   localparam int TDUR_W   = 24;
   localparam int MST_W    = 3;
   localparam int POS_W    = 7;
   localparam int LEN_W    = 7;
   localparam int SPEED_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int CMD_W    = 2;

   // Divider: one quotient bit per cycle
   localparam int DIV_STEPS = TDUR_W;
   localparam int DIV_CNT_W = 5;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_STEP   = 2'd0;
   localparam logic [OP_W-1:0] OP_ACTION = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;

   // User actions
   localparam logic [ACT_W-1:0] ACT_STOP  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_PLAY  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_PAUSE = 2'd2;

   // Commands
   localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

   // Player states
   localparam logic [MST_W-1:0] ST_WAIT_START  = 3'd0;
   localparam logic [MST_W-1:0] ST_WAIT_NOTE   = 3'd1;
   localparam logic [MST_W-1:0] ST_PLAY_NOTE   = 3'd2;
   localparam logic [MST_W-1:0] ST_PAUSED      = 3'd3;
   localparam logic [MST_W-1:0] ST_WAIT_MELODY = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOADED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED  = 2'd2;

   // Note table entry: frequency over duration
   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
   } note_entry_type;

endpackage

// ===== src/mns_divider.sv =====
// Radix-2 restoring divider: 24-bit dividend by 16-bit divisor.
// Depends on mns_pkg; one quotient bit per cycle, done pulses after the last.
module mns_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mns_pkg::TDUR_W-1:0]   dividend,
   input  logic [mns_pkg::SPEED_W-1:0]  divisor,
   output logic                         done,
   output logic [mns_pkg::TDUR_W-1:0]   quotient
);
   import mns_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TDUR_W-1:0]      quo_ff, quo_in;
   logic [SPEED_W-1:0]     rem_ff, rem_in;
   logic [SPEED_W-1:0]     div_ff, div_in;
   logic [SPEED_W:0]       rem_sh;
   logic                   fits;

   // One trial subtraction per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[TDUR_W-1]};
      fits    = rem_sh >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? SPEED_W'(rem_sh - {1'b0, div_ff}) : rem_sh[SPEED_W-1:0];
         quo_in = {quo_ff[TDUR_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control under reset, payload free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/mns_note_table.sv =====
// Note table memory: frequency and duration per entry, one write and one read port.
// Depends on mns_pkg; read data is registered, contents undefined until written.
module mns_note_table #(
   parameter int DEPTH  = 64,
   parameter int IDX_W  = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  mns_pkg::note_entry_type     wr_data,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_addr,
   output mns_pkg::note_entry_type     rd_data
);
   import mns_pkg::*;

   note_entry_type mem [DEPTH];
   note_entry_type rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/melody_note_sequencer.sv =====
// Melody note sequencer: five-state player controller over a note table.
// Depends on mns_pkg, mns_note_table, mns_divider and the assertion macros.
//
// One request beat is taken at a time; req_stall is high while it is worked.
// A table write, action change, step that starts no note or unused opcode goes
// through the DONE state to the result register and loads it once it is free.
// A step that starts a note goes through one note table read, the bit-serial
// divider that scales the duration by 256/speed, a hand-over of the quotient,
// then the load of the result register. The next request can be taken in the
// cycle after the result register loads. The result register lets the next
// request be taken while a result beat waits on rsp_stall. The note table is
// not cleared after reset; an entry read before it is written holds undefined
// data.
`include "melody_note_sequencer_assert.svh"

module melody_note_sequencer #(
   parameter int NOTE_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration
   input  logic                            csr_wr_en,
   input  logic [mns_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mns_pkg::CSR_DAT_W-1:0]   csr_wdata,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mns_pkg::OP_W-1:0]        req_opcode,
   input  logic [mns_pkg::ACT_W-1:0]       req_action,
   input  logic                            req_note_timeout,
   input  logic [mns_pkg::ADDR_W-1:0]      req_note_addr,
   input  logic [mns_pkg::FREQ_W-1:0]      req_note_freq,
   input  logic [mns_pkg::DUR_W-1:0]       req_note_duration,
   // Result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mns_pkg::CMD_W-1:0]       rsp_command,
   output logic [mns_pkg::FREQ_W-1:0]      rsp_tone_freq,
   output logic [mns_pkg::TDUR_W-1:0]      rsp_tone_duration,
   output logic [mns_pkg::MST_W-1:0]       rsp_player_state,
   output logic [mns_pkg::ACT_W-1:0]       rsp_current_action,
   output logic                            rsp_active
);
   import mns_pkg::*;

   localparam int IDX_W = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
   localparam int EXT_W = (IDX_W > POS_W) ? IDX_W : POS_W;

   // Sequencer codes
   localparam logic [1:0] SEQ_IDLE = 2'd0;
   localparam logic [1:0] SEQ_READ = 2'd1;
   localparam logic [1:0] SEQ_DIV  = 2'd2;
   localparam logic [1:0] SEQ_DONE = 2'd3;

   // Configuration registers
   logic [LEN_W-1:0]    length_ff;
   logic                loaded_ff;
   logic [SPEED_W-1:0]  speed_ff;

   // Player state
   logic [MST_W-1:0]    mstate_ff, mstate_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [ACT_W-1:0]    action_ff, action_in;

   // Sequencer and per-beat holding
   logic [1:0]          seq_ff, seq_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic                pos_ok_ff;
   logic [FREQ_W-1:0]   freq_hold_ff;
   logic [TDUR_W-1:0]   dur_hold_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [CMD_W-1:0]    rsp_cmd_ff;
   logic [FREQ_W-1:0]   rsp_freq_ff;
   logic [TDUR_W-1:0]   rsp_dur_ff;
   logic [MST_W-1:0]    rsp_mstate_ff;
   logic [ACT_W-1:0]    rsp_action_ff;
   logic                rsp_active_ff;

   logic                req_take;
   logic                start_note;
   logic                at_end;
   logic                pos_ok;
   logic                rsp_load;
   logic                rsp_free;
   logic [EXT_W-1:0]    pos_ext;
   logic [EXT_W-1:0]    addr_ext;
   logic                tbl_wr_en;
   note_entry_type      tbl_wr_data;
   note_entry_type      tbl_rd_data;
   logic                div_start;
   logic                div_done;
   logic [TDUR_W-1:0]   div_quotient;
   logic [TDUR_W-1:0]   div_dividend;
   logic [SPEED_W-1:0]  div_divisor;

   assign req_stall = (seq_ff != SEQ_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (seq_ff == SEQ_DONE) && rsp_free;

   assign pos_ext  = EXT_W'(pos_ff);
   assign addr_ext = EXT_W'(req_note_addr);
   assign pos_ok   = 32'(pos_ff) < NOTE_DEPTH;
   assign at_end   = pos_ff >= length_ff;

   // Decide the transition for the accepted beat
   always_comb begin
      mstate_in  = mstate_ff;
      pos_in     = pos_ff;
      action_in  = action_ff;
      cmd_in     = CMD_NONE;
      start_note = 1'b0;
      tbl_wr_en  = 1'b0;
      case (req_opcode)
         OP_STEP: begin
            case (mstate_ff)
               ST_WAIT_START, ST_WAIT_MELODY: begin
                  if (loaded_ff && action_ff == ACT_PLAY) begin
                     start_note = 1'b1;
                  end
               end
               ST_WAIT_NOTE: begin
                  if (req_note_timeout) begin
                     cmd_in    = CMD_STOP;
                     mstate_in = ST_PLAY_NOTE;
                  end
               end
               ST_PLAY_NOTE: begin
                  if (action_ff == ACT_PLAY && !at_end) begin
                     start_note = 1'b1;
                  end else if (action_ff == ACT_STOP) begin
                     cmd_in    = CMD_STOP;
                     pos_in    = '0;
                     mstate_in = ST_WAIT_START;
                  end else if (action_ff == ACT_PAUSE) begin
                     cmd_in    = CMD_STOP;
                     mstate_in = ST_PAUSED;
                  end else if (at_end) begin
                     cmd_in    = CMD_STOP;
                     pos_in    = '0;
                     action_in = ACT_STOP;
                     mstate_in = ST_WAIT_MELODY;
                  end
               end
               ST_PAUSED: begin
                  if (action_ff == ACT_PLAY) begin
                     mstate_in = ST_PLAY_NOTE;
                  end
               end
               default: begin
                  mstate_in = ST_WAIT_START;
               end
            endcase
            if (start_note) begin
               cmd_in    = CMD_START;
               pos_in    = pos_ff + 1'b1;
               mstate_in = ST_WAIT_NOTE;
            end
         end
         OP_ACTION: begin
            if (req_action inside {ACT_STOP, ACT_PLAY, ACT_PAUSE}) begin
               action_in = req_action;
               if (req_action == ACT_STOP) begin
                  pos_in = '0;
               end
            end
         end
         OP_WRITE: begin
            tbl_wr_en = 32'(req_note_addr) < NOTE_DEPTH;
         end
         default: begin
         end
      endcase
   end

   // Step the sequencer
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE: begin
            if (req_take) begin
               seq_in = (start_note && req_opcode == OP_STEP) ? SEQ_READ : SEQ_DONE;
            end
         end
         SEQ_READ: seq_in = SEQ_DIV;
         SEQ_DIV: begin
            if (div_done) begin
               seq_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (rsp_free) begin
               seq_in = SEQ_IDLE;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   // Table port and divider operands
   assign tbl_wr_data.freq = req_note_freq;
   assign tbl_wr_data.dur  = req_note_duration;
   assign div_start    = (seq_ff == SEQ_READ);
   assign div_dividend = pos_ok_ff ? {tbl_rd_data.dur, 8'h00} : '0;
   assign div_divisor  = (speed_ff == '0) ? SPEED_W'(1) : speed_ff;

   mns_note_table #(
      .DEPTH (NOTE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_take && tbl_wr_en),
      .wr_addr (addr_ext[IDX_W-1:0]),
      .wr_data (tbl_wr_data),
      .rd_en   (req_take),
      .rd_addr (pos_ext[IDX_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   mns_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_W'(1);
         loaded_ff <= 1'b0;
         speed_ff  <= SPEED_W'(256);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LENGTH: length_ff <= csr_wdata[LEN_W-1:0];
            CSR_LOADED: loaded_ff <= csr_wdata[0];
            CSR_SPEED:  speed_ff  <= csr_wdata[SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Player state and sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= SEQ_IDLE;
         mstate_ff <= ST_WAIT_START;
         pos_ff    <= '0;
         action_ff <= ACT_STOP;
         cmd_ff    <= CMD_NONE;
      end else begin
         seq_ff <= seq_in;
         if (req_take) begin
            mstate_ff <= mstate_in;
            pos_ff    <= pos_in;
            action_ff <= action_in;
            cmd_ff    <= cmd_in;
         end
      end
   end

   // Hold note data for the pending start command
   always_ff @(posedge clock) begin
      if (req_take) begin
         pos_ok_ff <= pos_ok;
      end
      if (seq_ff == SEQ_READ) begin
         freq_hold_ff <= pos_ok_ff ? tbl_rd_data.freq : '0;
      end
      if (div_done) begin
         dur_hold_ff <= div_quotient;
      end
   end

   // Result register: load when free, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_cmd_ff    <= cmd_ff;
         rsp_freq_ff   <= (cmd_ff == CMD_START) ? freq_hold_ff : '0;
         rsp_dur_ff    <= (cmd_ff == CMD_START) ? dur_hold_ff : '0;
         rsp_mstate_ff <= mstate_ff;
         rsp_action_ff <= action_ff;
         rsp_active_ff <= (action_ff == ACT_PLAY);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command        = rsp_cmd_ff;
   assign rsp_tone_freq      = rsp_freq_ff;
   assign rsp_tone_duration  = rsp_dur_ff;
   assign rsp_player_state   = rsp_mstate_ff;
   assign rsp_current_action = rsp_action_ff;
   assign rsp_active         = rsp_active_ff;

   // Checks
   `MNS_ASSERT_IMPLY(a_start_goes_wait_note,
      rsp_valid && rsp_command == CMD_START, rsp_player_state == ST_WAIT_NOTE,
      "start beat must leave the player waiting on the note")
   `MNS_ASSERT_IMPLY(a_tone_zero_without_start,
      rsp_valid && rsp_command != CMD_START, rsp_tone_freq == '0 && rsp_tone_duration == '0,
      "tone fields must be zero without a start command")
   `MNS_ASSERT_IMPLY(a_div_done_in_div,
      div_done, seq_ff == SEQ_DIV,
      "divider finished outside the divide phase")
   `MNS_ASSERT_NEXT(a_read_then_div,
      seq_ff == SEQ_READ, seq_ff == SEQ_DIV && !div_done,
      "note read must hand over to a running divide")

endmodule

// ===== tb/melody_note_sequencer_test.sv =====
// Self-checking testbench for the melody note sequencer.
// Depends on mns_pkg and the melody_note_sequencer RTL; predicts every result beat.
`timescale 1ns / 1ps

module melody_note_sequencer_test;
   import mns_pkg::*;

   localparam int NOTE_DEPTH  = 64;
   localparam int STUCK_LIMIT = 2000;

   // Codes the package leaves unnamed
   localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
   localparam logic [ACT_W-1:0] ACT_INVALID = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ACT_W-1:0]  action;
      logic              timeout;
      logic [ADDR_W-1:0] addr;
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
   } player_req_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [FREQ_W-1:0] tone_freq;
      logic [TDUR_W-1:0] tone_dur;
      logic [MST_W-1:0]  state;
      logic [ACT_W-1:0]  act;
      logic              active;
   } player_rsp_type;

   // Block ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LENGTH;
   logic [CSR_DAT_W-1:0]  csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_opcode = OP_STEP;
   logic [ACT_W-1:0]      req_action = ACT_STOP;
   logic                  req_note_timeout = 1'b0;
   logic [ADDR_W-1:0]     req_note_addr = '0;
   logic [FREQ_W-1:0]     req_note_freq = '0;
   logic [DUR_W-1:0]      req_note_duration = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CMD_W-1:0]      rsp_command;
   logic [FREQ_W-1:0]     rsp_tone_freq;
   logic [TDUR_W-1:0]     rsp_tone_duration;
   logic [MST_W-1:0]      rsp_player_state;
   logic [ACT_W-1:0]      rsp_current_action;
   logic                  rsp_active;

   // Player mirror: state, settings and note table
   logic [MST_W-1:0]      play_state = ST_WAIT_START;
   logic [POS_W-1:0]      note_pos = '0;
   logic [ACT_W-1:0]      user_act = ACT_STOP;
   logic [LEN_W-1:0]      melody_len = 7'd1;
   logic                  melody_ready = 1'b0;
   logic [SPEED_W-1:0]    play_speed = 16'd256;
   logic [FREQ_W-1:0]     freq_tab [NOTE_DEPTH];
   logic [DUR_W-1:0]      dur_tab [NOTE_DEPTH];
   bit                    entry_written [NOTE_DEPTH];
   player_rsp_type        player_outcomes [$];
   player_rsp_type        want_rsp;

   // Traffic shaping and bookkeeping
   int idle_pct = 0;
   int stall_pct = 0;
   int holdoff_left = 0;
   int stuck_cycles = 0;
   int mismatches = 0;
   int beats_sent = 0;
   int results_seen = 0;
   int note_starts = 0;
   int sound_stops = 0;
   int settings_applied = 0;

   melody_note_sequencer #(.NOTE_DEPTH(NOTE_DEPTH)) uut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_action         (req_action),
      .req_note_timeout   (req_note_timeout),
      .req_note_addr      (req_note_addr),
      .req_note_freq      (req_note_freq),
      .req_note_duration  (req_note_duration),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_command        (rsp_command),
      .rsp_tone_freq      (rsp_tone_freq),
      .rsp_tone_duration  (rsp_tone_duration),
      .rsp_player_state   (rsp_player_state),
      .rsp_current_action (rsp_current_action),
      .rsp_active         (rsp_active)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Print one mismatch line and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("%0t ns: %s mismatch, got 'h%0h, want 'h%0h", $time, what, got, want);
   endtask

   // True when a machine step from the current mirror state starts a note
   function automatic bit would_start_note();
      return ((play_state == ST_WAIT_START || play_state == ST_WAIT_MELODY) &&
              melody_ready && user_act == ACT_PLAY) ||
             (play_state == ST_PLAY_NOTE && user_act == ACT_PLAY && note_pos < melody_len);
   endfunction

   // Advance the player mirror by one accepted beat and queue its result
   task automatic advance_player(input player_req_type b);
      player_rsp_type     r;
      logic [31:0]        span;
      logic [SPEED_W-1:0] divisor;
      r = '0;
      span = '0;
      case (b.opcode)
         OP_STEP: begin
            if (would_start_note()) begin
               // Past the table the note plays as a silent zero-length one
               if (note_pos < NOTE_DEPTH) begin
                  r.tone_freq = freq_tab[note_pos[ADDR_W-1:0]];
                  span = {8'h00, dur_tab[note_pos[ADDR_W-1:0]], 8'h00};
               end
               divisor = (play_speed == '0) ? 16'd1 : play_speed;
               span = span / {16'h0000, divisor};
               r.command = CMD_START;
               r.tone_dur = span[TDUR_W-1:0];
               note_pos = note_pos + 1'b1;
               play_state = ST_WAIT_NOTE;
            end else begin
               case (play_state)
                  ST_WAIT_NOTE: if (b.timeout) begin
                     r.command = CMD_STOP;
                     play_state = ST_PLAY_NOTE;
                  end
                  ST_PLAY_NOTE: begin
                     if (user_act == ACT_STOP) begin
                        r.command = CMD_STOP;
                        note_pos = '0;
                        play_state = ST_WAIT_START;
                     end else if (user_act == ACT_PAUSE) begin
                        r.command = CMD_STOP;
                        play_state = ST_PAUSED;
                     end else if (note_pos >= melody_len) begin
                        r.command = CMD_STOP;
                        note_pos = '0;
                        user_act = ACT_STOP;
                        play_state = ST_WAIT_MELODY;
                     end
                  end
                  ST_PAUSED: if (user_act == ACT_PLAY) begin
                     play_state = ST_PLAY_NOTE;
                  end
                  ST_WAIT_START, ST_WAIT_MELODY: ;
                  default: play_state = ST_WAIT_START;
               endcase
            end
         end
         OP_ACTION: if (b.action != ACT_INVALID) begin
            user_act = b.action;
            if (b.action == ACT_STOP)
               note_pos = '0;
         end
         OP_WRITE: begin
            freq_tab[b.addr] = b.freq;
            dur_tab[b.addr] = b.dur;
            entry_written[b.addr] = 1'b1;
         end
         default: ;
      endcase
      if (r.command == CMD_START)
         note_starts++;
      if (r.command == CMD_STOP)
         sound_stops++;
      r.state = play_state;
      r.act = user_act;
      r.active = (user_act == ACT_PLAY);
      player_outcomes.push_back(r);
   endtask

   // Offer one beat, hold it until taken, then fold it into the mirror
   task automatic send_beat(input player_req_type b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= b.opcode;
      req_action <= b.action;
      req_note_timeout <= b.timeout;
      req_note_addr <= b.addr;
      req_note_freq <= b.freq;
      req_note_duration <= b.dur;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      advance_player(b);
      beats_sent++;
   endtask

   // Beat with random content in every field, then the opcode forced
   function automatic player_req_type filler_beat(input logic [OP_W-1:0] op);
      player_req_type b;
      b.action = ACT_W'($urandom);
      b.timeout = 1'($urandom);
      b.addr = ADDR_W'($urandom);
      b.freq = FREQ_W'($urandom);
      b.dur = DUR_W'($urandom);
      b.opcode = op;
      return b;
   endfunction

   // Never let a step read a table entry that was not written: fill it first
   task automatic issue(input player_req_type b);
      player_req_type fill;
      if (b.opcode == OP_STEP && would_start_note() && note_pos < NOTE_DEPTH &&
          !entry_written[note_pos[ADDR_W-1:0]]) begin
         fill = filler_beat(OP_WRITE);
         fill.addr = note_pos[ADDR_W-1:0];
         send_beat(fill);
      end
      send_beat(b);
   endtask

   task automatic do_step(input logic tmo);
      player_req_type b;
      b = filler_beat(OP_STEP);
      b.timeout = tmo;
      issue(b);
   endtask

   task automatic do_action(input logic [ACT_W-1:0] act);
      player_req_type b;
      b = filler_beat(OP_ACTION);
      b.action = act;
      issue(b);
   endtask

   task automatic do_write(input logic [ADDR_W-1:0] addr, input logic [FREQ_W-1:0] f,
                           input logic [DUR_W-1:0] d);
      player_req_type b;
      b = filler_beat(OP_WRITE);
      b.addr = addr;
      b.freq = f;
      b.dur = d;
      issue(b);
   endtask

   // Press play, then per note: a step that starts it and a step that times it out
   task automatic play_notes(input int count);
      do_action(ACT_PLAY);
      repeat (count) begin
         do_step(1'b0);
         do_step(1'b1);
      end
   endtask

   // Drop valid and hold off until every pending result beat is back
   task automatic settle();
      req_valid <= 1'b0;
      while (player_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_LENGTH: melody_len = data[LEN_W-1:0];
         CSR_LOADED: melody_ready = data[0];
         CSR_SPEED:  play_speed = data[SPEED_W-1:0];
         default: ;
      endcase
   endtask

   // Write all three registers while the block sits idle
   task automatic apply_settings(input logic [LEN_W-1:0] len, input logic ready,
                                 input logic [SPEED_W-1:0] spd);
      settle();
      write_reg(CSR_LENGTH, CSR_DAT_W'(len));
      write_reg(CSR_LOADED, CSR_DAT_W'(ready));
      write_reg(CSR_SPEED, spd);
      csr_wr_en <= 1'b0;
      settings_applied++;
   endtask

   // Table writes, ignored codes, a two-note melody to its end, pause and stop
   task automatic test_directed_basics();
      apply_settings(7'd2, 1'b0, 16'd256);
      do_write(6'd0, '1, '1);
      do_write(6'd1, 20'h5A5A5, 16'hA5A5);
      do_write(6'd63, '0, '0);
      do_step(1'b1);
      do_action(ACT_PLAY);
      do_step(1'b0);
      issue(filler_beat(OP_UNUSED));
      do_action(ACT_INVALID);
      apply_settings(7'd2, 1'b1, 16'd256);
      play_notes(2);
      do_step(1'b0);
      do_action(ACT_PLAY);
      do_step(1'b0);
      do_step(1'b0);
      do_step(1'b1);
      do_action(ACT_PAUSE);
      do_step(1'b0);
      do_step(1'b1);
      do_action(ACT_PLAY);
      do_step(1'b0);
      do_action(ACT_STOP);
      do_step(1'b0);
   endtask

   // Duration scaling at the speed extremes, zero speed included
   task automatic test_playback_speeds();
      logic [SPEED_W-1:0] speeds [5];
      speeds = '{16'd1, 16'hFFFF, 16'd0, 16'd128, 16'd300};
      foreach (speeds[i]) begin
         apply_settings(7'd3, 1'b1, speeds[i]);
         do_action(ACT_STOP);
         play_notes(3);
      end
   endtask

   // Melodies longer than the table, and one exactly as long as it
   task automatic test_long_melody();
      apply_settings(7'd127, 1'b1, 16'd256);
      do_action(ACT_STOP);
      play_notes(128);
      apply_settings(7'd64, 1'b1, 16'd512);
      do_action(ACT_STOP);
      play_notes(65);
   endtask

   // Receiver holds off long enough for the block to stall its input
   task automatic test_backpressure();
      idle_pct = 0;
      stall_pct = 0;
      settle();
      holdoff_left = 400;
      do_action(ACT_STOP);
      play_notes(5);
      settle();
   endtask

   // Mostly playback traffic with random content, plus noise beats
   function automatic player_req_type random_beat();
      player_req_type b;
      int             pick;
      int             sel;
      b = filler_beat(OP_STEP);
      pick = $urandom_range(99);
      sel = $urandom_range(19);
      if (pick < 55) begin
         if (play_state == ST_WAIT_NOTE)
            b.timeout = (sel < 16);
      end else if (pick < 72) begin
         b.opcode = OP_ACTION;
         b.action = (sel < 12) ? ACT_PLAY : (sel < 15) ? ACT_PAUSE :
                    (sel < 18) ? ACT_STOP : ACT_INVALID;
      end else if (pick < 94) begin
         b.opcode = OP_WRITE;
         if (sel == 0) begin
            b.freq = '1;
            b.dur = '1;
         end else if (sel == 1) begin
            b.freq = '0;
            b.dur = '0;
         end
      end else begin
         b.opcode = OP_UNUSED;
      end
      return b;
   endfunction

   task automatic test_random_traffic(input int idle, input int stall);
      logic [LEN_W-1:0]   len;
      logic [SPEED_W-1:0] spd;
      idle_pct = idle;
      stall_pct = stall;
      repeat (3) begin
         case ($urandom_range(6))
            0: len = 7'd1;
            1: len = 7'd64;
            2: len = 7'd127;
            3: len = 7'd0;
            4: len = LEN_W'($urandom_range(8, 2));
            default: len = LEN_W'($urandom_range(64, 1));
         endcase
         case ($urandom_range(5))
            0: spd = 16'd256;
            1: spd = 16'd1;
            2: spd = 16'hFFFF;
            3: spd = 16'd0;
            4: spd = SPEED_W'($urandom_range(1024, 64));
            default: spd = SPEED_W'($urandom);
         endcase
         apply_settings(len, $urandom_range(4) != 0, spd);
         repeat (110)
            issue(random_beat());
      end
   endtask

   // Receiver: long hold-off when requested, random stalls otherwise
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left = holdoff_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (player_outcomes.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(rsp_command), 0);
         end else begin
            want_rsp = player_outcomes.pop_front();
            results_seen++;
            if (rsp_command !== want_rsp.command)
               report_mismatch("command", 32'(rsp_command), 32'(want_rsp.command));
            if (rsp_tone_freq !== want_rsp.tone_freq)
               report_mismatch("tone_freq", 32'(rsp_tone_freq), 32'(want_rsp.tone_freq));
            if (rsp_tone_duration !== want_rsp.tone_dur)
               report_mismatch("tone_duration", 32'(rsp_tone_duration), 32'(want_rsp.tone_dur));
            if (rsp_player_state !== want_rsp.state)
               report_mismatch("player_state", 32'(rsp_player_state), 32'(want_rsp.state));
            if (rsp_current_action !== want_rsp.act)
               report_mismatch("current_action", 32'(rsp_current_action), 32'(want_rsp.act));
            if (rsp_active !== want_rsp.active)
               report_mismatch("active", 32'(rsp_active), 32'(want_rsp.active));
         end
      end
   end

   // Watchdog: abort when no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STUCK_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_playback_speeds();
      test_long_melody();
      test_backpressure();
      test_random_traffic(0, 0);
      test_random_traffic(65, 0);
      test_random_traffic(0, 65);
      test_random_traffic(8, 8);
      settle();
      repeat (30) @(posedge clock);
      if (player_outcomes.size() != 0)
         report_mismatch("results never delivered", player_outcomes.size(), 0);
      $display("Covered %0d request beats and %0d result beats over %0d register settings;",
               beats_sent, results_seen, settings_applied);
      $display("the player started %0d notes and stopped sound %0d times.",
               note_starts, sound_stops);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== melody_note_sequencer.f =====
+incdir+src
src/mns_pkg.sv
src/mns_divider.sv
src/mns_note_table.sv
src/melody_note_sequencer.sv
tb/melody_note_sequencer_test.sv
